// ----- rtl/row_span_visit_table_core_defines.svh -----
// assertion macros for the row span visit table
`ifndef ROW_SPAN_VISIT_TABLE_CORE_DEFINES_SVH
`define ROW_SPAN_VISIT_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define RSVT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsvt assertion failed");
// next-cycle implication, disabled during reset
`define RSVT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsvt assertion failed");
`else
`define RSVT_ASSERT_IMP(lbl, ante, cons)
`define RSVT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/rsvt_pkg.sv -----
// shared constants, codes and controller/datapath interface types
package rsvt_pkg;

  localparam int MAX_ROWS_DEF   = 1024;
  localparam int MAX_SPANS_DEF  = 16;
  localparam int COORD_BITS_DEF = 16;

  localparam int          IMG_W     = 11;
  localparam logic [10:0] IMG_RESET = 11'd1024;

  // skip check steps this far past the right end of a covering span
  localparam int SKIP_STEP = 2;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CHECK = 2'd1;
  localparam logic [1:0] OP_SKIP  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_NOROW = 2'd3;

  typedef struct packed {
    logic ready;
    logic accept;
    logic clear_step;
    logic count_load;
    logic scan;
    logic write;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic go_scan;
    logic go_write;
    logic match;
    logic last;
    logic is_add;
    logic room;
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/rsvt_ram.sv -----
// generic simple dual-port ram with registered read
module rsvt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rsvt_ctrl.sv -----
// sequencing state machine: clearing pass, count read, span scan, write, result
module rsvt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  rsvt_pkg::stat_t st,
  output rsvt_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_COUNT = 6'b000100,
    S_SCAN  = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd.count_load = 1'b1;
        if (st.go_scan) begin
          state_next = S_SCAN;
        end else if (st.go_write) begin
          state_next = S_WRITE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.match) begin
          state_next = S_DONE;
        end else if (st.last) begin
          state_next = (st.is_add && st.room) ? S_WRITE : S_DONE;
        end
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/rsvt_dp.sv -----
// datapath: word registers, count and span memories, span compare, result register
module rsvt_dp #(
  parameter  int MAX_ROWS   = rsvt_pkg::MAX_ROWS_DEF,
  parameter  int MAX_SPANS  = rsvt_pkg::MAX_SPANS_DEF,
  parameter  int COORD_BITS = rsvt_pkg::COORD_BITS_DEF,
  localparam int IN_W       = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W      = ((COORD_BITS + 4 + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rsvt_pkg::cmd_t           cmd,
  output rsvt_pkg::stat_t          st,
  input  logic [IN_W-1:0]          s_tdata,
  input  logic [1:0]               s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_W-1:0]         m_tdata,
  input  logic                     cfg_valid,
  input  logic [rsvt_pkg::IMG_W-1:0] cfg_data
);

  localparam int CB    = COORD_BITS;
  localparam int NW    = CB + 1;
  localparam int RB    = $clog2(MAX_ROWS);
  localparam int SB    = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
  localparam int CW    = $clog2(MAX_SPANS + 1);
  localparam int RXW   = (RB > CB) ? RB : CB;
  localparam int SW    = ((NW > rsvt_pkg::IMG_W) ? NW : rsvt_pkg::IMG_W) + 1;
  localparam int SDEPTH = MAX_ROWS * (1 << SB);
  localparam int PADW  = OUT_W - (CB + 4);

  // input word fields
  logic [CB-1:0]  in_row;
  logic [RXW-1:0] in_row_u;
  logic [RB-1:0]  in_row_idx;
  logic           in_stored;
  logic           in_image;

  assign in_row     = s_tdata[CB-1:0];
  assign in_row_u   = RXW'(in_row);
  assign in_row_idx = in_row_u[RB-1:0];
  assign in_stored  = !in_row[CB-1] && (33'(in_row_u) < 33'(MAX_ROWS));

  // latched item
  logic [1:0]                 op_q;
  logic [RB-1:0]              row_q;
  logic                       stored_q;
  logic                       in_image_q;
  logic [CB-1:0]              lx_q, rx_q, x_q;
  logic [CW-1:0]              n_q;
  logic [CW-1:0]              rd_idx, cmp_idx;
  logic                       cmp_valid;
  logic                       hit;
  logic [CB-1:0]              hit_right;
  logic [RB-1:0]              clr_idx;
  logic [rsvt_pkg::IMG_W-1:0] img;

  assign in_image = !in_row[CB-1] && (33'(in_row_u) < 33'(img));

  // memories
  logic          cnt_we;
  logic [RB-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata, cnt_rdata, cnt_now;
  logic [2*CB-1:0] span_rdata;
  logic [CB-1:0]   span_left, span_right;

  assign cnt_we    = cmd.clear_step || cmd.write;
  assign cnt_waddr = cmd.clear_step ? clr_idx : row_q;
  assign cnt_wdata = cmd.clear_step ? '0 : n_q + CW'(1);

  rsvt_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_ROWS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (in_row_idx),
    .rdata (cnt_rdata)
  );

  rsvt_ram #(
    .WIDTH (2 * CB),
    .DEPTH (SDEPTH)
  ) u_span_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr ({row_q, n_q[SB-1:0]}),
    .wdata ({rx_q, lx_q}),
    .raddr ({row_q, rd_idx[SB-1:0]}),
    .rdata (span_rdata)
  );

  assign span_left  = span_rdata[CB-1:0];
  assign span_right = span_rdata[2*CB-1:CB];
  assign cnt_now    = stored_q ? cnt_rdata : '0;

  // span compare
  logic is_add, is_check, is_skip;
  logic match_add, match_cov, match, issue;

  assign is_add    = (op_q == rsvt_pkg::OP_ADD);
  assign is_check  = (op_q == rsvt_pkg::OP_CHECK);
  assign is_skip   = (op_q == rsvt_pkg::OP_SKIP);
  assign match_add = (span_left == lx_q) && (span_right == rx_q);
  assign match_cov = ($signed(x_q) <= $signed(span_right)) &&
                     ($signed(span_left) <= $signed(x_q));
  assign match     = cmp_valid && (is_add ? match_add : match_cov);
  assign issue     = (rd_idx < n_q);

  always_comb begin
    st            = '0;
    st.clear_last = (clr_idx == RB'(MAX_ROWS - 1));
    st.go_scan    = (cnt_now != '0) && ((is_add && stored_q) ||
                    ((is_check || is_skip) && in_image_q));
    st.go_write   = is_add && stored_q && (cnt_now == '0);
    st.match      = match;
    st.last       = cmp_valid && (cmp_idx == n_q - CW'(1));
    st.is_add     = is_add;
    st.room       = (n_q < CW'(MAX_SPANS));
    st.out_free   = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q       <= s_tuser;
      row_q      <= in_row_idx;
      stored_q   <= in_stored;
      in_image_q <= in_image;
      lx_q       <= s_tdata[2*CB-1:CB];
      rx_q       <= s_tdata[3*CB-1:2*CB];
      x_q        <= s_tdata[4*CB-1:3*CB];
      rd_idx     <= '0;
    end else if (cmd.scan && issue) begin
      rd_idx <= rd_idx + CW'(1);
    end
    if (cmd.count_load) begin
      n_q <= cnt_now;
      hit <= 1'b0;
    end else if (cmd.scan && match) begin
      hit       <= 1'b1;
      hit_right <= span_right;
    end
    cmp_idx <= rd_idx;
  end

  // compare slot follows the read issue in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
      clr_idx   <= '0;
      img       <= rsvt_pkg::IMG_RESET;
    end else begin
      cmp_valid <= cmd.scan && issue;
      if (cmd.clear_step) begin
        clr_idx <= clr_idx + RB'(1);
      end
      if (cfg_valid) begin
        img <= cfg_data;
      end
    end
  end

  // result
  logic [SW-1:0] skip_sum;
  logic [NW-1:0] x_ext, right_step;
  logic          res_free;
  logic [NW-1:0] res_next;
  logic [1:0]    res_status;

  assign skip_sum   = {{(SW - CB){x_q[CB-1]}}, x_q} +
                      {{(SW - rsvt_pkg::IMG_W){1'b0}}, img};
  assign x_ext      = {x_q[CB-1], x_q};
  assign right_step = {hit_right[CB-1], hit_right} + NW'(rsvt_pkg::SKIP_STEP);

  always_comb begin
    res_free   = 1'b0;
    res_next   = '0;
    res_status = rsvt_pkg::ST_OK;
    case (op_q)
      rsvt_pkg::OP_ADD: begin
        if (!stored_q) begin
          res_status = rsvt_pkg::ST_NOROW;
        end else if (hit) begin
          res_status = rsvt_pkg::ST_DUP;
        end else if (!st.room) begin
          res_status = rsvt_pkg::ST_FULL;
        end
      end
      rsvt_pkg::OP_CHECK: begin
        res_status = stored_q ? rsvt_pkg::ST_OK : rsvt_pkg::ST_NOROW;
        res_next   = x_ext;
        if (n_q == '0) begin
          res_free = 1'b1;
        end else if (!in_image_q) begin
          res_free = 1'b0;
        end else begin
          res_free = !hit;
        end
      end
      rsvt_pkg::OP_SKIP: begin
        res_status = stored_q ? rsvt_pkg::ST_OK : rsvt_pkg::ST_NOROW;
        if (!in_image_q) begin
          res_next = skip_sum[NW-1:0];
        end else if (hit) begin
          res_next = right_step;
        end else begin
          res_free = 1'b1;
          res_next = x_ext;
        end
      end
      default: begin
        res_status = rsvt_pkg::ST_OK;
      end
    endcase
  end

  logic          out_free_q;
  logic [NW-1:0] out_next;
  logic [1:0]    out_status;

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_free_q <= res_free;
      out_next   <= res_next;
      out_status <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.result_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  generate
    if (PADW > 0) begin : g_pad
      assign m_tdata = {{PADW{1'b0}}, out_status, out_next, out_free_q};
    end else begin : g_nopad
      assign m_tdata = {out_status, out_next, out_free_q};
    end
  endgenerate

endmodule

// ----- rtl/row_span_visit_table_core.sv -----
// top level of the row span visit table: controller, datapath and port wiring
// Keeps up to MAX_SPANS visited spans per row for MAX_ROWS rows and answers one
// word at a time: add a span, check a point, or check a point and get the column
// to continue from. Each word reads the row's span count, scans the stored
// spans of that row through the span memory read port, one span per cycle with a
// registered read, stopping early at the first hit, optionally writes the new
// span and loads the result register. The next word is taken once the result is
// loaded, even while it still waits on m_tready. After reset a clearing pass over
// all MAX_ROWS rows zeroes the span counts; s_tready stays low during it, while
// image_size writes on the cfg channel are taken at any time.
`include "row_span_visit_table_core_defines.svh"

module row_span_visit_table_core #(
  parameter  int MAX_ROWS   = rsvt_pkg::MAX_ROWS_DEF,
  parameter  int MAX_SPANS  = rsvt_pkg::MAX_SPANS_DEF,
  parameter  int COORD_BITS = rsvt_pkg::COORD_BITS_DEF,
  localparam int IN_W       = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W      = ((COORD_BITS + 4 + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [IN_W-1:0]            s_tdata,   // row, left_x, right_x, x_coord, zero pad
  input  logic [1:0]                 s_tuser,   // op
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [OUT_W-1:0]           m_tdata,   // is_free, next_x, status, zero pad
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rsvt_pkg::IMG_W-1:0] cfg_data   // image_size
);

  rsvt_pkg::cmd_t  cmd;
  rsvt_pkg::stat_t st;

  assign s_tready  = cmd.ready;
  assign cfg_ready = 1'b1;

  rsvt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .st       (st),
    .cmd      (cmd)
  );

  rsvt_dp #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_SPANS  (MAX_SPANS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data)
  );

  // one word in flight: no new word right after one is taken
  `RSVT_ASSERT_NXT(a_one_word, s_tvalid && s_tready, !s_tready)
  // a result load always shows up on the output
  `RSVT_ASSERT_NXT(a_result_shown, cmd.result_load, m_tvalid)
  // a span is never appended to a full row
  `RSVT_ASSERT_IMP(a_write_room, cmd.write, st.room)
  // no word taken during the clearing pass
  `RSVT_ASSERT_IMP(a_clear_closed, cmd.clear_step, !s_tready)

endmodule

// ----- sim/tb.sv -----
// testbench for row_span_visit_table_core: stream words in, check results against a predictor
`timescale 1ns / 1ps

module tb;

  localparam int TABLE_ROWS  = 1024;
  localparam int ROW_SPANS   = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTS  = 40;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] row;
    logic signed [15:0] lx;
    logic signed [15:0] rx;
    logic signed [15:0] x;
  } span_word_t;

  typedef struct packed {
    logic        is_free;
    logic [16:0] next_x;
    logic [1:0]  status;
  } visit_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // row, left_x, right_x, x_coord
  logic [1:0]  s_tuser = '0;   // op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // is_free, next_x, status, zero pad
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;  // image_size

  row_span_visit_table_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // predictor copy of the span table
  int                 image_rows = 1024;
  logic [4:0]         row_span_cnt [0:TABLE_ROWS-1];
  logic signed [15:0] span_lo [0:TABLE_ROWS*ROW_SPANS-1];
  logic signed [15:0] span_hi [0:TABLE_ROWS*ROW_SPANS-1];

  span_word_t    pending_words[$];
  visit_result_t awaited_results[$];
  span_word_t    shown_word = '0;

  logic word_taken = 1'b0;
  logic result_taken = 1'b0;
  bit   sender_calm = 1'b0;
  bit   sink_calm = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   cycle_count = 0;
  int   mismatch_count = 0;
  int   results_checked = 0;
  int   op_seen [0:3] = '{0, 0, 0, 0};
  int   status_seen [0:3] = '{0, 0, 0, 0};

  function automatic visit_result_t apply_span_op(span_word_t w);
    visit_result_t res;
    int row_i, xi, n, base, hit, i, nxt;
    bit stored, in_image, dup;
    logic [31:0] nbits;
    row_i = $signed(w.row);
    xi = $signed(w.x);
    stored = row_i >= 0 && row_i < TABLE_ROWS;
    in_image = row_i >= 0 && row_i < image_rows;
    n = stored ? int'(row_span_cnt[row_i]) : 0;
    base = stored ? row_i * ROW_SPANS : 0;
    res.is_free = 1'b0;
    res.status = stored ? rsvt_pkg::ST_OK : rsvt_pkg::ST_NOROW;
    nxt = 0;
    // first covering span in storage order
    hit = -1;
    for (i = 0; i < n; i++) begin
      if (hit < 0 && xi <= int'(span_hi[base + i]) && int'(span_lo[base + i]) <= xi) hit = i;
    end
    case (w.op)
      rsvt_pkg::OP_ADD: begin
        if (stored) begin
          dup = 1'b0;
          for (i = 0; i < n; i++)
            if (span_lo[base + i] == w.lx && span_hi[base + i] == w.rx) dup = 1'b1;
          if (dup) begin
            res.status = rsvt_pkg::ST_DUP;
          end else if (n >= ROW_SPANS) begin
            res.status = rsvt_pkg::ST_FULL;
          end else begin
            span_lo[base + n] = w.lx;
            span_hi[base + n] = w.rx;
            row_span_cnt[row_i] = 5'(n + 1);
          end
        end
      end
      rsvt_pkg::OP_CHECK: begin
        nxt = xi;
        if (n == 0) res.is_free = 1'b1;
        else if (!in_image) res.is_free = 1'b0;
        else res.is_free = (hit < 0);
      end
      rsvt_pkg::OP_SKIP: begin
        if (!in_image) begin
          nxt = xi + image_rows;
        end else if (n == 0) begin
          res.is_free = 1'b1;
          nxt = xi;
        end else if (hit >= 0) begin
          nxt = int'(span_hi[base + hit]) + rsvt_pkg::SKIP_STEP;
        end else begin
          res.is_free = 1'b1;
          nxt = xi;
        end
      end
      default: begin
        res.status = rsvt_pkg::ST_OK;
      end
    endcase
    nbits = nxt;
    res.next_x = nbits[16:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // sender: words change at the falling edge
  always @(negedge clk) begin : drive_words
    span_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else if (s_tvalid && !word_taken) begin
      // word still waiting on s_tready
    end else begin
      if (word_taken) begin
        if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
        gap_left = sender_calm ? 0 : $urandom_range(0, 14);
      end
      if (gap_left > 0 || pending_words.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_tvalid <= 1'b0;
      end else begin
        w = pending_words.pop_front();
        shown_word <= w;
        s_tdata <= {w.x, w.rx, w.lx, w.row};
        s_tuser <= w.op;
        s_tvalid <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : take_words
    visit_result_t r;
    word_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      r = apply_span_op(shown_word);
      awaited_results = {awaited_results, r};
      op_seen[shown_word.op]++;
      status_seen[r.status]++;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_taken) begin
        if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
        stall_left = sink_calm ? 0 : $urandom_range(0, 14);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    visit_result_t want;
    visit_result_t got;
    result_taken <= !rst && m_tvalid && m_tready;
    if (!rst && m_tvalid && m_tready) begin
      got.is_free = m_tdata[0];
      got.next_x = m_tdata[17:1];
      got.status = m_tdata[19:18];
      if (awaited_results.size() == 0) begin
        report_mismatch("result word with nothing awaited");
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (got.is_free !== want.is_free)
          report_mismatch($sformatf("is_free %b, want %b", got.is_free, want.is_free));
        if (got.next_x !== want.next_x)
          report_mismatch($sformatf("next_x %h, want %h", got.next_x, want.next_x));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_word(input logic [1:0] op, input int row, input int lx, input int rx,
                            input int x);
    span_word_t w;
    w.op = op;
    w.row = 16'(row);
    w.lx = 16'(lx);
    w.rx = 16'(rx);
    w.x = 16'(x);
    pending_words = {pending_words, w};
  endtask

  // hold off until the block has answered everything sent so far
  task automatic wait_drained();
    while (pending_words.size() != 0 || s_tvalid || awaited_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_image_size(input int v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= 11'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    image_rows = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int sizes [0:4];
    int hot_rows [0:5];
    int ph, k, pick, row, lx, rx, x;
    logic [1:0] op;
    sizes = '{700, 0, 1024, 1, 37};
    foreach (row_span_cnt[i]) row_span_cnt[i] = '0;
    foreach (span_lo[i]) span_lo[i] = '0;
    foreach (span_hi[i]) span_hi[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty row, fill to full, duplicate on a full row, hits and misses
    queue_word(rsvt_pkg::OP_CHECK, 3, 0, 0, 0);
    queue_word(rsvt_pkg::OP_SKIP, 3, 0, 0, -32768);
    for (k = 0; k < 16; k++) queue_word(rsvt_pkg::OP_ADD, 3, 16 * k, 16 * k + 5, 0);
    queue_word(rsvt_pkg::OP_ADD, 3, 0, 5, 0);
    queue_word(rsvt_pkg::OP_ADD, 3, 300, 301, 0);
    queue_word(rsvt_pkg::OP_CHECK, 3, 0, 0, 243);
    queue_word(rsvt_pkg::OP_SKIP, 3, 0, 0, 243);
    queue_word(rsvt_pkg::OP_SKIP, 3, 0, 0, 246);
    // rows with no storage and row 0, extremes of every field
    queue_word(rsvt_pkg::OP_ADD, -32768, -32768, 32767, 0);
    queue_word(rsvt_pkg::OP_CHECK, 32767, 0, 0, 32767);
    queue_word(rsvt_pkg::OP_SKIP, 1024, 0, 0, 32767);
    queue_word(rsvt_pkg::OP_NONE, -1, -1, -1, -1);
    queue_word(rsvt_pkg::OP_ADD, 0, -32768, 32767, 0);
    queue_word(rsvt_pkg::OP_SKIP, 0, 0, 0, 32767);
    wait_drained();

    // stored row with spans but outside a tiny image
    write_image_size(2);
    queue_word(rsvt_pkg::OP_CHECK, 3, 0, 0, 243);
    queue_word(rsvt_pkg::OP_SKIP, 3, 0, 0, -1);
    wait_drained();

    for (ph = 0; ph < 5; ph++) begin
      write_image_size(sizes[ph]);
      for (k = 0; k < 5; k++) hot_rows[k] = $urandom_range(0, TABLE_ROWS - 1);
      hot_rows[5] = (sizes[ph] > 0) ? $urandom_range(0, sizes[ph] - 1) : 0;
      for (k = 0; k < 150; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) row = hot_rows[$urandom_range(0, 5)];
        else if (pick < 80) row = sizes[ph] - 1 + $urandom_range(0, 1);
        else if (pick < 88) row = $urandom_range(0, TABLE_ROWS - 1);
        else row = $urandom_range(0, 65535);
        pick = $urandom_range(0, 19);
        if (pick < 8) op = rsvt_pkg::OP_ADD;
        else if (pick < 13) op = rsvt_pkg::OP_CHECK;
        else if (pick < 19) op = rsvt_pkg::OP_SKIP;
        else op = rsvt_pkg::OP_NONE;
        // small span pool so rows fill up and duplicates recur
        if ($urandom_range(0, 7) == 0) begin
          lx = $urandom_range(0, 65535);
          rx = $urandom_range(0, 65535);
        end else begin
          lx = 8 * $urandom_range(0, 24);
          rx = lx + 2 * $urandom_range(0, 3);
        end
        x = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 240);
        queue_word(op, row, lx, rx, x);
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    $display("covered %0d adds, %0d plain checks, %0d skip checks, %0d unused op words",
             op_seen[rsvt_pkg::OP_ADD], op_seen[rsvt_pkg::OP_CHECK],
             op_seen[rsvt_pkg::OP_SKIP], op_seen[rsvt_pkg::OP_NONE]);
    $display("%0d duplicate, %0d row full, %0d row not stored; %0d results checked",
             status_seen[rsvt_pkg::ST_DUP], status_seen[rsvt_pkg::ST_FULL],
             status_seen[rsvt_pkg::ST_NOROW], results_checked);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rsvt_pkg.sv
rtl/rsvt_ram.sv
rtl/rsvt_ctrl.sv
rtl/rsvt_dp.sv
rtl/row_span_visit_table_core.sv
sim/tb.sv
